// ----- rtl/ksrf_pkg.sv -----
// Shared types, constants and a table function for the keyboard sequence remap filter.
package ksrf_pkg;

    // Map storage geometry
    localparam int MAP_ENTRIES = 94;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);

    // Result framing: up to four leading bytes plus the final byte
    localparam int MAX_PRE = 4;
    localparam int MAX_RES = MAX_PRE + 1;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Configuration port
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_KEY_STYLE  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_KOI_ENABLE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_PASS8_MODE = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_F11_REMAP  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_RUS_KEY    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LAT_KEY    = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_META_KEY   = 3'd6;

    // Operation codes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_MAP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Byte codes
    localparam logic [7:0] B_NUL    = 8'h00;
    localparam logic [7:0] B_BS     = 8'h08;
    localparam logic [7:0] B_LF     = 8'h0A;
    localparam logic [7:0] B_SO     = 8'h0E;
    localparam logic [7:0] B_SI     = 8'h0F;
    localparam logic [7:0] B_ESC    = 8'h1B;
    localparam logic [7:0] B_SPACE  = 8'h20;
    localparam logic [7:0] B_BANG   = 8'h21;
    localparam logic [7:0] B_ZERO   = 8'h30;
    localparam logic [7:0] B_NINE   = 8'h39;
    localparam logic [7:0] B_QUEST  = 8'h3F;
    localparam logic [7:0] B_AT     = 8'h40;
    localparam logic [7:0] B_O      = 8'h4F;
    localparam logic [7:0] B_UPZ    = 8'h5A;
    localparam logic [7:0] B_LBRACK = 8'h5B;
    localparam logic [7:0] B_UNDER  = 8'h5F;
    localparam logic [7:0] B_LOWZ   = 8'h7A;
    localparam logic [7:0] B_TILDE  = 8'h7E;
    localparam logic [7:0] B_META   = 8'h80;
    localparam logic [7:0] B_SS3    = 8'h8F;
    localparam logic [7:0] B_CSI    = 8'h9B;

    // Remapped function key numbers
    localparam logic [6:0] FK_ESC = 7'd23;
    localparam logic [6:0] FK_BS  = 7'd24;
    localparam logic [6:0] FK_LF  = 7'd25;

    // Control sequence parser states
    typedef enum logic [5:0] {
        SQ_GROUND = 6'b000001,
        SQ_CSI    = 6'b000010,
        SQ_ONE    = 6'b000100,
        SQ_TWO    = 6'b001000,
        SQ_WAIT   = 6'b010000,
        SQ_SS3    = 6'b100000
    } t_seq;

    // Results of one keyboard word, before the map lookup resolves
    typedef struct packed {
        logic [CNT_W-1:0]           n_pre;
        logic [MAX_PRE-1:0][7:0]    pre;
        logic                       pre_term;
        logic                       go;
        logic [7:0]                 fin;
        logic                       use_map;
    } t_pkt;

    // Map memory access
    typedef struct packed {
        logic              wr_en;
        logic [MAP_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [MAP_AW-1:0] rd_addr;
    } t_map_req;

    // Default map contents for one entry
    function automatic logic [7:0] map_default(input logic [MAP_AW-1:0] idx);
        logic [7:0] ch;
        ch = 8'(idx) + B_BANG;
        if (ch <= B_QUEST)      return ch;
        else if (ch <= B_UPZ)   return ch | 8'hA0;
        else if (ch <= B_UNDER) return ch | B_META;
        else if (ch <= B_LOWZ)  return ch ^ 8'hA0;
        else                    return ch | B_META;
    endfunction

endpackage

// ----- rtl/ksrf_map.sv -----
// Writable character map: synchronous RAM with per-entry valid bits over a default table.
module ksrf_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ksrf_pkg::t_map_req            i_req,
    output logic [7:0]                    o_rd_data
);

    logic [7:0]                     mem [ksrf_pkg::MAP_ENTRIES];
    logic [ksrf_pkg::MAP_ENTRIES-1:0] r_valid;
    logic [7:0]                     r_rd_mem;
    logic [7:0]                     r_rd_def;
    logic                           r_rd_hit;

    // Storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_mem <= mem[i_req.rd_addr];
            r_rd_def <= ksrf_pkg::map_default(i_req.rd_addr);
        end
    end

    // Valid bits: an entry never written reads as its default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_mem : r_rd_def;

endmodule

// ----- rtl/ksrf_ctrl.sv -----
// Configuration registers, sequence parser state and per-word decode.
module ksrf_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [1:0]                         i_operation,
    input  logic [7:0]                         i_key_byte,
    input  logic [6:0]                         i_map_index,
    input  logic [7:0]                         i_map_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ksrf_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    output ksrf_pkg::t_pkt                     o_pkt,
    output ksrf_pkg::t_map_req                 o_map_req
);

    // Configuration
    logic       r_key_style, r_koi, r_pass8, r_f11;
    logic [7:0] r_rus_key, r_lat_key, r_meta_key;

    // Filter state; key number kept as two decimal digits
    ksrf_pkg::t_seq r_seq, n_seq;
    logic [3:0]     r_kn_hi, n_kn_hi, r_kn_lo, n_kn_lo;
    logic           r_rus, n_rus, r_meta, n_meta, r_inseq, n_inseq;

    logic           cfg_wr;
    logic           is_digit, fw_wait, fw_clr;
    logic [7:0]     fn;
    logic [7:0]     fin;
    logic           go, use_map;
    logic [ksrf_pkg::CNT_W-1:0]           n_pre, rp_n;
    logic [ksrf_pkg::MAX_PRE-1:0][7:0]    pre, rp_pre;
    logic           pre_term;
    logic [7:0]     map_addr_full;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Byte classes
    assign is_digit = (i_key_byte >= ksrf_pkg::B_ZERO) && (i_key_byte <= ksrf_pkg::B_NINE);
    assign fw_wait  = (i_key_byte >= ksrf_pkg::B_SPACE) && (i_key_byte <= ksrf_pkg::B_QUEST);
    assign fw_clr   = !((i_key_byte >= ksrf_pkg::B_SPACE) && (i_key_byte <= ksrf_pkg::B_TILDE));

    // Binary key number from the digit pair
    assign fn = {1'b0, r_kn_hi, 3'b000} + {2'b00, r_kn_hi, 1'b0} + {4'b0000, r_kn_lo};

    // Held part of a sequence, replayed in 7-bit form
    always_comb begin
        rp_n   = '0;
        rp_pre = '0;
        unique case (r_seq)
            ksrf_pkg::SQ_CSI: begin
                rp_n      = ksrf_pkg::CNT_W'(2);
                rp_pre[0] = ksrf_pkg::B_ESC;
                rp_pre[1] = ksrf_pkg::B_LBRACK;
            end
            ksrf_pkg::SQ_ONE: begin
                rp_n      = ksrf_pkg::CNT_W'(3);
                rp_pre[0] = ksrf_pkg::B_ESC;
                rp_pre[1] = ksrf_pkg::B_LBRACK;
                rp_pre[2] = ksrf_pkg::B_ZERO + {4'b0000, r_kn_lo};
            end
            ksrf_pkg::SQ_TWO: begin
                rp_n      = ksrf_pkg::CNT_W'(4);
                rp_pre[0] = ksrf_pkg::B_ESC;
                rp_pre[1] = ksrf_pkg::B_LBRACK;
                rp_pre[2] = ksrf_pkg::B_ZERO + {4'b0000, r_kn_hi};
                rp_pre[3] = ksrf_pkg::B_ZERO + {4'b0000, r_kn_lo};
            end
            default: begin
                rp_n   = '0;
                rp_pre = '0;
            end
        endcase
    end

    // Decode of one accepted word
    always_comb begin
        n_seq    = r_seq;
        n_kn_hi  = r_kn_hi;
        n_kn_lo  = r_kn_lo;
        n_rus    = r_rus;
        n_meta   = r_meta;
        n_inseq  = r_inseq;
        go       = 1'b0;
        fin      = i_key_byte;
        n_pre    = '0;
        pre      = '0;
        pre_term = 1'b0;
        use_map  = 1'b0;

        if (i_accept && (i_operation == ksrf_pkg::OP_CLEAR)) begin
            n_rus  = 1'b0;
            n_meta = 1'b0;
        end else if (i_accept && (i_operation == ksrf_pkg::OP_KEY)) begin
            if (!r_key_style) begin
                // single-byte switch keys
                priority if (i_key_byte == ksrf_pkg::B_NUL) begin
                    go = 1'b1;
                end else if (i_key_byte == r_rus_key && r_koi) begin
                    n_rus  = 1'b1;
                    n_meta = 1'b0;
                    if (!r_pass8) begin
                        n_pre    = ksrf_pkg::CNT_W'(1);
                        pre[0]   = ksrf_pkg::B_SO;
                        pre_term = 1'b1;
                    end
                end else if (i_key_byte == r_lat_key && r_koi) begin
                    n_rus  = 1'b0;
                    n_meta = 1'b0;
                    if (!r_pass8) begin
                        n_pre    = ksrf_pkg::CNT_W'(1);
                        pre[0]   = ksrf_pkg::B_SI;
                        pre_term = 1'b1;
                    end
                end else if (i_key_byte == r_meta_key) begin
                    n_meta = 1'b1;
                end else begin
                    go = 1'b1;
                end
            end else if (i_key_byte == ksrf_pkg::B_CSI) begin
                n_seq   = ksrf_pkg::SQ_CSI;
                n_inseq = 1'b1;
                n_meta  = 1'b0;
            end else if (i_key_byte == ksrf_pkg::B_SS3) begin
                n_seq   = ksrf_pkg::SQ_SS3;
                n_inseq = 1'b1;
                n_meta  = 1'b0;
                n_pre   = ksrf_pkg::CNT_W'(1);
                pre[0]  = ksrf_pkg::B_ESC;
                fin     = ksrf_pkg::B_O;
                go      = 1'b1;
            end else if (r_seq == ksrf_pkg::SQ_CSI && is_digit) begin
                n_kn_hi = 4'd0;
                n_kn_lo = i_key_byte[3:0];
                n_seq   = ksrf_pkg::SQ_ONE;
            end else if (r_seq == ksrf_pkg::SQ_ONE && is_digit) begin
                n_kn_hi = r_kn_lo;
                n_kn_lo = i_key_byte[3:0];
                n_seq   = ksrf_pkg::SQ_TWO;
            end else if ((r_seq == ksrf_pkg::SQ_ONE || r_seq == ksrf_pkg::SQ_TWO)
                         && i_key_byte == ksrf_pkg::B_TILDE) begin
                // completed function key
                n_seq = ksrf_pkg::SQ_GROUND;
                priority if (fn == r_rus_key && r_koi) begin
                    n_rus   = 1'b1;
                    n_meta  = 1'b0;
                    n_inseq = 1'b0;
                    if (!r_pass8) begin
                        n_pre    = ksrf_pkg::CNT_W'(1);
                        pre[0]   = ksrf_pkg::B_SO;
                        pre_term = 1'b1;
                    end
                end else if (fn == r_lat_key && r_koi) begin
                    n_rus   = 1'b0;
                    n_meta  = 1'b0;
                    n_inseq = 1'b0;
                    if (!r_pass8) begin
                        n_pre    = ksrf_pkg::CNT_W'(1);
                        pre[0]   = ksrf_pkg::B_SI;
                        pre_term = 1'b1;
                    end
                end else if (fn == r_meta_key) begin
                    n_meta  = 1'b1;
                    n_inseq = 1'b0;
                end else if (r_f11 && fn[6:0] == ksrf_pkg::FK_ESC) begin
                    fin = ksrf_pkg::B_ESC;
                    go  = 1'b1;
                end else if (r_f11 && fn[6:0] == ksrf_pkg::FK_BS) begin
                    fin = ksrf_pkg::B_BS;
                    go  = 1'b1;
                end else if (r_f11 && fn[6:0] == ksrf_pkg::FK_LF) begin
                    fin = ksrf_pkg::B_LF;
                    go  = 1'b1;
                end else begin
                    n_pre = rp_n;
                    pre   = rp_pre;
                    go    = 1'b1;
                end
            end else if (r_seq == ksrf_pkg::SQ_CSI || r_seq == ksrf_pkg::SQ_ONE
                         || r_seq == ksrf_pkg::SQ_TWO || r_seq == ksrf_pkg::SQ_WAIT) begin
                // broken sequence: replay then finish on the final byte class
                n_pre = rp_n;
                pre   = rp_pre;
                go    = 1'b1;
                n_seq = fw_wait ? ksrf_pkg::SQ_WAIT : ksrf_pkg::SQ_GROUND;
                if (fw_clr) begin
                    n_inseq = 1'b0;
                end
            end else begin
                n_seq = ksrf_pkg::SQ_GROUND;
                go    = 1'b1;
            end

            // META and Russian map on the byte that goes on
            if (go) begin
                if (n_meta && !n_inseq) begin
                    n_meta = 1'b0;
                    fin    = fin | ksrf_pkg::B_META;
                end else if (n_rus && !n_inseq && r_koi && fin >= ksrf_pkg::B_BANG
                             && fin <= ksrf_pkg::B_TILDE) begin
                    use_map = 1'b1;
                end
                if (r_key_style && n_seq == ksrf_pkg::SQ_GROUND) begin
                    n_inseq = 1'b0;
                end
            end
        end
    end

    // Map requests
    assign map_addr_full     = fin - ksrf_pkg::B_BANG;
    assign o_map_req.rd_en   = i_accept && use_map;
    assign o_map_req.rd_addr = map_addr_full[ksrf_pkg::MAP_AW-1:0];
    assign o_map_req.wr_en   = i_accept && (i_operation == ksrf_pkg::OP_MAP)
                               && (i_map_index < 7'(ksrf_pkg::MAP_ENTRIES));
    assign o_map_req.wr_addr = i_map_index[ksrf_pkg::MAP_AW-1:0];
    assign o_map_req.wr_data = i_map_value;

    assign o_pkt.n_pre    = n_pre;
    assign o_pkt.pre      = pre;
    assign o_pkt.pre_term = pre_term;
    assign o_pkt.go       = go;
    assign o_pkt.fin      = fin;
    assign o_pkt.use_map  = use_map;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_style <= 1'b0;
            r_koi       <= 1'b1;
            r_pass8     <= 1'b0;
            r_f11       <= 1'b0;
            r_rus_key   <= ksrf_pkg::B_SO;
            r_lat_key   <= ksrf_pkg::B_SI;
            r_meta_key  <= ksrf_pkg::B_NUL;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                ksrf_pkg::CFG_KEY_STYLE:  r_key_style <= i_cfg_data[0];
                ksrf_pkg::CFG_KOI_ENABLE: r_koi       <= i_cfg_data[0];
                ksrf_pkg::CFG_PASS8_MODE: r_pass8     <= i_cfg_data[0];
                ksrf_pkg::CFG_F11_REMAP:  r_f11       <= i_cfg_data[0];
                ksrf_pkg::CFG_RUS_KEY:    r_rus_key   <= i_cfg_data;
                ksrf_pkg::CFG_LAT_KEY:    r_lat_key   <= i_cfg_data;
                ksrf_pkg::CFG_META_KEY:   r_meta_key  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Filter state; a key style write drops any open sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= ksrf_pkg::SQ_GROUND;
            r_kn_hi <= 4'd0;
            r_kn_lo <= 4'd0;
            r_rus   <= 1'b0;
            r_meta  <= 1'b0;
            r_inseq <= 1'b0;
        end else begin
            r_kn_hi <= n_kn_hi;
            r_kn_lo <= n_kn_lo;
            r_rus   <= n_rus;
            r_meta  <= n_meta;
            if (cfg_wr && i_cfg_index == ksrf_pkg::CFG_KEY_STYLE) begin
                r_seq   <= ksrf_pkg::SQ_GROUND;
                r_inseq <= 1'b0;
            end else begin
                r_seq   <= n_seq;
                r_inseq <= n_inseq;
            end
        end
    end

endmodule

// ----- rtl/ksrf_emit.sv -----
// Output buffer: assembles one word's results and sends them one per cycle while the receiver is ready.
module ksrf_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    output logic               o_load_ready,
    input  ksrf_pkg::t_pkt     i_pkt,
    input  logic [7:0]         i_map_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_term,
    output logic               o_last
);

    logic [7:0]                         r_byte [ksrf_pkg::MAX_RES];
    logic [ksrf_pkg::MAX_RES-1:0]       r_term;
    logic [ksrf_pkg::CNT_W-1:0]         r_cnt;
    logic [7:0]                         fin_res;
    logic [ksrf_pkg::MAX_RES-1:0][7:0]  pre_ext;
    logic [7:0]                         asm_byte [ksrf_pkg::MAX_RES];
    logic [ksrf_pkg::MAX_RES-1:0]       asm_term;
    logic [ksrf_pkg::CNT_W-1:0]         asm_cnt;
    logic                               load, pop;

    // Place leading bytes, then the final byte
    assign fin_res = i_pkt.use_map ? i_map_data : i_pkt.fin;
    assign pre_ext = {fin_res, i_pkt.pre};
    assign asm_cnt = i_pkt.n_pre + ksrf_pkg::CNT_W'(i_pkt.go);

    always_comb begin
        for (int k = 0; k < ksrf_pkg::MAX_RES; k++) begin
            if (ksrf_pkg::CNT_W'(k) < i_pkt.n_pre) begin
                asm_byte[k] = pre_ext[k];
                asm_term[k] = i_pkt.pre_term;
            end else begin
                asm_byte[k] = fin_res;
                asm_term[k] = 1'b0;
            end
        end
    end

    assign o_valid      = (r_cnt != '0);
    assign pop          = o_valid && i_ready;
    assign o_load_ready = (r_cnt == '0) || ((r_cnt == ksrf_pkg::CNT_W'(1)) && i_ready);
    assign load         = i_load && o_load_ready;

    assign o_byte = r_byte[0];
    assign o_term = r_term[0];
    assign o_last = (r_cnt == ksrf_pkg::CNT_W'(1));

    // Count of bytes left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= asm_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - ksrf_pkg::CNT_W'(1);
        end
    end

    // Byte shift line
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < ksrf_pkg::MAX_RES; k++) begin
                r_byte[k] <= asm_byte[k];
            end
            r_term <= asm_term;
        end else if (pop) begin
            for (int k = 0; k < ksrf_pkg::MAX_RES - 1; k++) begin
                r_byte[k] <= r_byte[k+1];
            end
            r_term <= {1'b0, r_term[ksrf_pkg::MAX_RES-1:1]};
        end
    end

endmodule

// ----- rtl/keyboard_sequence_remap_filter_top.sv -----
// Keyboard sequence remap filter: decode, map memory and output buffer.
// The first result of a word is offered once the word has passed the map read stage
// and been loaded into the output buffer. A word has 0 to 5 results; they leave one per
// cycle while the receiver is ready, and a new word is taken while the previous one drains.
// Reset (synchronous, i_rst_n low): config and filter state to defaults, map valid bits
// cleared so every map entry reads its default until written; no clearing pass.
module keyboard_sequence_remap_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_operation,
    input  logic [7:0]                     i_key_byte,
    input  logic [6:0]                     i_map_index,
    input  logic [7:0]                     i_map_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_to_terminal,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ksrf_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    ksrf_pkg::t_pkt     pkt, r_s2_pkt;
    ksrf_pkg::t_map_req map_req;
    logic               r_s2_valid;
    logic               accept, load_ready;
    logic [7:0]         map_data;

    assign o_ready = !r_s2_valid || load_ready;
    assign accept  = i_valid && o_ready;

    ksrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_key_byte  (i_key_byte),
        .i_map_index (i_map_index),
        .i_map_value (i_map_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pkt       (pkt),
        .o_map_req   (map_req)
    );

    ksrf_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_data)
    );

    // Stage that waits for the map read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (accept) begin
            r_s2_valid <= 1'b1;
        end else if (load_ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_pkt <= pkt;
        end
    end

    ksrf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_s2_valid),
        .o_load_ready (load_ready),
        .i_pkt        (r_s2_pkt),
        .i_map_data   (map_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte       (o_out_byte),
        .o_term       (o_to_terminal),
        .o_last       (o_last)
    );

endmodule

// ----- bench/keyboard_filter_checker.sv -----
// Checker for the keyboard sequence remap filter: predicts every result word and compares.
module keyboard_filter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_key_byte,
    input  logic [6:0]                  i_map_index,
    input  logic [7:0]                  i_map_value,
    // result channel
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [7:0]                  i_out_byte,
    input  logic                        i_to_terminal,
    input  logic                        i_last,
    // configuration channel
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [ksrf_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    output int                          o_mismatches,
    output int                          o_pending
);
    import ksrf_pkg::*;

    // One result word
    typedef struct packed {
        logic [7:0] data;
        logic       term;
        logic       last;
    } key_out_t;

    key_out_t expected_out[$];
    key_out_t word_out[$];

    // Configuration copy
    logic       seq_keys;
    logic       koi_on;
    logic       pass8_on;
    logic       f11_on;
    logic [7:0] rus_sel;
    logic [7:0] lat_sel;
    logic [7:0] meta_sel;

    // Filter state copy
    t_seq       seq_st;
    logic [6:0] fkey_num;
    logic       rus_on;
    logic       meta_armed;
    logic       in_esc;
    logic [7:0] remap [MAP_ENTRIES];

    task automatic emit(input logic [7:0] b, input logic term);
        word_out.push_back('{data: b, term: term, last: 1'b0});
    endtask

    // SO/SI echo toward the terminal unless pass8 is set
    task automatic echo_shift(input logic [7:0] b);
        if (!pass8_on)
            emit(b, 1'b1);
    endtask

    // Resend the held part of a CSI sequence in 7-bit form
    task automatic replay_held();
        if (seq_st inside {SQ_CSI, SQ_ONE, SQ_TWO}) begin
            emit(B_ESC, 1'b0);
            emit(B_LBRACK, 1'b0);
        end
        if (seq_st == SQ_ONE)
            emit(B_ZERO + 8'(fkey_num % 7'd10), 1'b0);
        if (seq_st == SQ_TWO) begin
            emit(B_ZERO + 8'((fkey_num / 7'd10) % 7'd10), 1'b0);
            emit(B_ZERO + 8'(fkey_num % 7'd10), 1'b0);
        end
    endtask

    // Byte after the held part: parameter bytes wait, finals return to ground, other bytes also end the escape
    task automatic close_param(input logic [7:0] c);
        if (c >= B_SPACE && c <= B_QUEST) begin
            seq_st = SQ_WAIT;
        end else if (c >= B_AT && c <= B_TILDE) begin
            seq_st = SQ_GROUND;
        end else begin
            seq_st = SQ_GROUND;
            in_esc = 1'b0;
        end
    endtask

    // Numbered function key closed by a tilde
    task automatic finish_fkey(inout logic [7:0] c, output logic go);
        go = 1'b0;
        if ({1'b0, fkey_num} == rus_sel && koi_on) begin
            seq_st     = SQ_GROUND;
            rus_on     = 1'b1;
            meta_armed = 1'b0;
            in_esc     = 1'b0;
            echo_shift(B_SO);
        end else if ({1'b0, fkey_num} == lat_sel && koi_on) begin
            seq_st     = SQ_GROUND;
            rus_on     = 1'b0;
            meta_armed = 1'b0;
            in_esc     = 1'b0;
            echo_shift(B_SI);
        end else if ({1'b0, fkey_num} == meta_sel) begin
            seq_st     = SQ_GROUND;
            meta_armed = 1'b1;
            in_esc     = 1'b0;
        end else if (f11_on && fkey_num inside {FK_ESC, FK_BS, FK_LF}) begin
            seq_st = SQ_GROUND;
            c      = (fkey_num == FK_ESC) ? B_ESC : (fkey_num == FK_BS) ? B_BS : B_LF;
            go     = 1'b1;
        end else begin
            replay_held();
            seq_st = SQ_GROUND;
            c      = B_TILDE;
            go     = 1'b1;
        end
    endtask

    // Expected results of one accepted input word
    task automatic predict_word(input logic [1:0] op, input logic [7:0] kb,
                                input logic [6:0] idx, input logic [7:0] val);
        logic [7:0] c;
        logic       go;
        logic       digit;
        c     = kb;
        go    = 1'b0;
        digit = (kb >= B_ZERO && kb <= B_NINE);
        word_out.delete();
        case (op)
            OP_MAP: begin
                if (idx < MAP_ENTRIES)
                    remap[idx] = val;
            end
            OP_CLEAR: begin
                rus_on     = 1'b0;
                meta_armed = 1'b0;
            end
            OP_KEY: begin
                if (!seq_keys) begin
                    // single-byte keys; a zero byte never switches
                    go = 1'b1;
                    if (c != B_NUL) begin
                        if (c == rus_sel && koi_on) begin
                            rus_on     = 1'b1;
                            meta_armed = 1'b0;
                            echo_shift(B_SO);
                            go         = 1'b0;
                        end else if (c == lat_sel && koi_on) begin
                            rus_on     = 1'b0;
                            meta_armed = 1'b0;
                            echo_shift(B_SI);
                            go         = 1'b0;
                        end else if (c == meta_sel) begin
                            meta_armed = 1'b1;
                            go         = 1'b0;
                        end
                    end
                end else if (c == B_CSI) begin
                    seq_st     = SQ_CSI;
                    in_esc     = 1'b1;
                    meta_armed = 1'b0;
                end else if (c == B_SS3) begin
                    seq_st     = SQ_SS3;
                    in_esc     = 1'b1;
                    meta_armed = 1'b0;
                    emit(B_ESC, 1'b0);
                    c          = B_O;
                    go         = 1'b1;
                end else begin
                    case (seq_st)
                        SQ_CSI: begin
                            if (digit) begin
                                fkey_num = 7'(c - B_ZERO);
                                seq_st   = SQ_ONE;
                            end else begin
                                replay_held();
                                close_param(c);
                                go = 1'b1;
                            end
                        end
                        SQ_ONE: begin
                            if (digit) begin
                                fkey_num = 7'((fkey_num % 7'd10) * 7'd10 + 7'(c - B_ZERO));
                                seq_st   = SQ_TWO;
                            end else if (c == B_TILDE) begin
                                finish_fkey(c, go);
                            end else begin
                                replay_held();
                                close_param(c);
                                go = 1'b1;
                            end
                        end
                        SQ_TWO: begin
                            if (c == B_TILDE) begin
                                finish_fkey(c, go);
                            end else begin
                                replay_held();
                                close_param(c);
                                go = 1'b1;
                            end
                        end
                        SQ_WAIT: begin
                            close_param(c);
                            go = 1'b1;
                        end
                        default: begin
                            seq_st = SQ_GROUND;
                            go     = 1'b1;
                        end
                    endcase
                end
                // META and Russian map apply only outside a sequence
                if (go) begin
                    if (meta_armed && !in_esc) begin
                        meta_armed = 1'b0;
                        c          = c | B_META;
                    end else if (rus_on && !in_esc && koi_on && c >= B_BANG && c <= B_TILDE) begin
                        c = remap[c - B_BANG];
                    end
                    if (seq_keys && seq_st == SQ_GROUND)
                        in_esc = 1'b0;
                    emit(c, 1'b0);
                end
            end
            default: ;
        endcase
        if (word_out.size() > 0) begin
            word_out[word_out.size() - 1].last = 1'b1;
            foreach (word_out[k])
                expected_out.push_back(word_out[k]);
        end
    endtask

    task automatic note_mismatch(input string what, input key_out_t want, input key_out_t got);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("%0t %s: expected byte %02h term %0b last %0b, got byte %02h term %0b last %0b",
                     $time, what, want.data, want.term, want.last, got.data, got.term, got.last);
    endtask

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin : monitor
        key_out_t   got;
        key_out_t   want;
        logic [7:0] ch;
        if (!i_rst_n) begin
            seq_keys     = 1'b0;
            koi_on       = 1'b1;
            pass8_on     = 1'b0;
            f11_on       = 1'b0;
            rus_sel      = 8'd14;
            lat_sel      = 8'd15;
            meta_sel     = 8'd0;
            seq_st       = SQ_GROUND;
            fkey_num     = '0;
            rus_on       = 1'b0;
            meta_armed   = 1'b0;
            in_esc       = 1'b0;
            o_mismatches = 0;
            expected_out.delete();
            // default table: punctuation and digits as is, letters shifted to the upper half
            for (int i = 0; i < MAP_ENTRIES; i++) begin
                ch = 8'(i) + B_BANG;
                if (ch <= B_QUEST)
                    remap[i] = ch;
                else if (ch <= B_UPZ)
                    remap[i] = ch | 8'hA0;
                else if (ch <= B_UNDER)
                    remap[i] = ch | B_META;
                else if (ch <= B_LOWZ)
                    remap[i] = ch ^ 8'hA0;
                else
                    remap[i] = ch | B_META;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_STYLE: begin
                        seq_keys = i_cfg_data[0];
                        seq_st   = SQ_GROUND;
                        in_esc   = 1'b0;
                    end
                    CFG_KOI_ENABLE: koi_on   = i_cfg_data[0];
                    CFG_PASS8_MODE: pass8_on = i_cfg_data[0];
                    CFG_F11_REMAP:  f11_on   = i_cfg_data[0];
                    CFG_RUS_KEY:    rus_sel  = i_cfg_data;
                    CFG_LAT_KEY:    lat_sel  = i_cfg_data;
                    CFG_META_KEY:   meta_sel = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_word(i_operation, i_key_byte, i_map_index, i_map_value);
            if (i_out_valid && i_out_ready) begin
                got = '{data: i_out_byte, term: i_to_terminal, last: i_last};
                if (expected_out.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = expected_out.pop_front();
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        o_pending = expected_out.size();
    end

endmodule

// ----- bench/keyboard_sequence_remap_filter_top_test.sv -----
// Testbench top for the keyboard sequence remap filter: stimulus, stalls and verdict.
module keyboard_sequence_remap_filter_top_test;
    import ksrf_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int PHASE_WORDS   = 40;
    localparam int LONG_HOLD     = 60;
    localparam int SETTLE_CYCLES = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_operation;
    logic [7:0]        i_key_byte;
    logic [6:0]        i_map_index;
    logic [7:0]        i_map_value;
    logic              o_valid;
    logic              i_ready;
    logic [7:0]        o_out_byte;
    logic              o_to_terminal;
    logic              o_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [7:0]        i_cfg_data;

    int   mismatches;
    int   pending;
    int   words_sent   = 0;
    int   burst_left   = 0;
    int   ready_pct    = 70;
    bit   sender_gappy = 1'b1;
    bit   hold_req     = 1'b0;

    // Settings last written, used to aim the random keys
    logic       cur_style;
    logic [7:0] cur_rus;
    logic [7:0] cur_lat;
    logic [7:0] cur_meta;

    keyboard_sequence_remap_filter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_key_byte    (i_key_byte),
        .i_map_index   (i_map_index),
        .i_map_value   (i_map_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_to_terminal (o_to_terminal),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    keyboard_filter_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_operation   (i_operation),
        .i_key_byte    (i_key_byte),
        .i_map_index   (i_map_index),
        .i_map_value   (i_map_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_byte    (o_out_byte),
        .i_to_terminal (o_to_terminal),
        .i_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when asked
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Offer one input word in bursts with gaps; returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] op, input logic [7:0] kb,
                             input logic [6:0] idx, input logic [7:0] val);
        if (sender_gappy && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key_byte  <= kb;
        i_map_index <= idx;
        i_map_value <= val;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (op != OP_SPARE && !(op == OP_MAP && idx >= MAP_ENTRIES))
            words_sent++;
    endtask

    task automatic key_word(input logic [7:0] b);
        send_word(OP_KEY, b, 7'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Write every register; the flag registers get random upper bits
    task automatic apply_config(input logic style, input logic koi, input logic pass8,
                                input logic f11, input logic [7:0] rus,
                                input logic [7:0] lat, input logic [7:0] meta);
        write_reg(CFG_KEY_STYLE,  {7'($urandom), style});
        write_reg(CFG_KOI_ENABLE, {7'($urandom), koi});
        write_reg(CFG_PASS8_MODE, {7'($urandom), pass8});
        write_reg(CFG_F11_REMAP,  {7'($urandom), f11});
        write_reg(CFG_RUS_KEY,    rus);
        write_reg(CFG_LAT_KEY,    lat);
        write_reg(CFG_META_KEY,   meta);
        i_cfg_valid <= 1'b0;
        cur_style = style;
        cur_rus   = rus;
        cur_lat   = lat;
        cur_meta  = meta;
    endtask

    // Stop offering, wait for every expected result, then let trailing work finish
    task automatic drain_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Single-byte traffic: keys aimed at the switch keys, map writes, clears, spare op
    task automatic random_plain_word();
        int         r;
        logic [7:0] kb;
        logic [6:0] idx;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            if ($urandom_range(0, 6) == 0)
                idx = 7'($urandom_range(MAP_ENTRIES, 127));
            else
                idx = 7'($urandom_range(0, MAP_ENTRIES - 1));
            send_word(OP_MAP, 8'($urandom), idx, 8'($urandom));
        end else if (r < 15) begin
            send_word(OP_CLEAR, 8'($urandom), 7'($urandom), 8'($urandom));
        end else if (r < 18) begin
            send_word(OP_SPARE, 8'($urandom), 7'($urandom), 8'($urandom));
        end else begin
            case ($urandom_range(0, 9))
                0:       kb = cur_rus;
                1:       kb = cur_lat;
                2:       kb = cur_meta;
                3:       kb = B_NUL;
                4, 5, 6: kb = 8'($urandom_range(B_BANG, B_TILDE));
                default: kb = 8'($urandom);
            endcase
            key_word(kb);
        end
    endtask

    // Sequence traffic: mostly well-formed CSI/SS3 sequences, some broken ones and noise
    task automatic random_seq_words();
        int         r;
        logic [7:0] num;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            // numbered function key
            case ($urandom_range(0, 6))
                0:       num = cur_rus;
                1:       num = cur_lat;
                2:       num = cur_meta;
                3:       num = {1'b0, FK_ESC};
                4:       num = {1'b0, FK_BS};
                5:       num = {1'b0, FK_LF};
                default: num = 8'($urandom_range(0, 99));
            endcase
            if (num > 99)
                num = 8'($urandom_range(0, 99));
            key_word(B_CSI);
            if (num > 9 || $urandom_range(0, 1) == 1)
                key_word(B_ZERO + num / 8'd10);
            key_word(B_ZERO + num % 8'd10);
            key_word(B_TILDE);
        end else if (r < 50) begin
            key_word(B_SS3);
            key_word(8'($urandom));
        end else if (r < 60) begin
            // parameters then a final byte
            key_word(B_CSI);
            repeat ($urandom_range(0, 2)) key_word(8'($urandom_range(B_SPACE, B_QUEST)));
            key_word(8'($urandom_range(B_AT, B_TILDE)));
        end else if (r < 70) begin
            // broken: digits cut off by an arbitrary byte
            key_word(B_CSI);
            repeat ($urandom_range(0, 3)) key_word(8'($urandom_range(B_ZERO, B_NINE)));
            key_word(8'($urandom));
        end else begin
            random_plain_word();
        end
    endtask

    initial begin : stimulus
        int phase_end;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_KEY;
        i_key_byte  = '0;
        i_map_index = '0;
        i_map_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KEY_STYLE;
        i_cfg_data  = '0;
        cur_style   = 1'b0;
        cur_rus     = 8'd14;
        cur_lat     = 8'd15;
        cur_meta    = 8'd0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-byte keys at reset settings: extremes, Russian map, map writes, clear
        key_word(B_NUL);
        key_word(8'hFF);
        key_word(cur_rus);
        key_word(B_BANG);
        send_word(OP_MAP, 8'($urandom), 7'd0, 8'hFF);
        send_word(OP_MAP, 8'($urandom), 7'(MAP_ENTRIES - 1), 8'h00);
        send_word(OP_MAP, 8'($urandom), 7'h7F, 8'h5A);
        key_word(B_BANG);
        key_word(B_TILDE);
        send_word(OP_SPARE, 8'($urandom), 7'($urandom), 8'($urandom));
        send_word(OP_CLEAR, 8'($urandom), 7'($urandom), 8'($urandom));
        key_word(B_TILDE);

        // META on a zero byte; switch echo suppressed
        drain_idle();
        apply_config(1'b0, 1'b1, 1'b1, 1'b0, 8'd14, 8'd15, 8'h01);
        key_word(8'h01);
        key_word(B_NUL);
        key_word(cur_lat);

        // Sequence style: remapped key 23, SS3, broken CSI, then a CSI left open
        drain_idle();
        apply_config(1'b1, 1'b1, 1'b0, 1'b1, 8'd14, 8'd15, 8'd99);
        key_word(B_CSI);
        key_word(B_ZERO + 8'd2);
        key_word(B_ZERO + 8'd3);
        key_word(B_TILDE);
        key_word(B_SS3);
        key_word(8'h41);
        key_word(B_CSI);
        key_word(B_ZERO + 8'd7);
        key_word(8'h78);
        key_word(B_CSI);

        // Random phases, each under its own settings and flow-control pattern
        for (int p = 0; p < 7; p++) begin
            drain_idle();
            case (p)
                0: begin
                    apply_config(1'b0, 1'b1, 1'b0, 1'b0, 8'd14, 8'd15, B_ESC);
                    ready_pct    = 100;
                    sender_gappy = 1'b0;
                end
                1: begin
                    apply_config(1'b1, 1'b1, 1'b0, 1'b1, 8'd26, 8'd28, 8'd29);
                    ready_pct    = 70;
                    sender_gappy = 1'b1;
                    hold_req     = 1'b1;
                end
                2: begin
                    apply_config(1'b1, 1'b0, 1'b1, 1'b0, 8'd23, 8'd24, 8'd99);
                    ready_pct    = 40;
                    sender_gappy = 1'b1;
                end
                3: begin
                    apply_config(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF, 8'h00, B_META);
                    ready_pct    = 85;
                    sender_gappy = 1'b1;
                end
                4: begin
                    apply_config(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 8'd99, 8'd9);
                    ready_pct    = 100;
                    sender_gappy = 1'b0;
                    hold_req     = 1'b1;
                end
                5: begin
                    apply_config(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                 8'($urandom_range(0, 120)), 8'($urandom_range(0, 120)),
                                 8'($urandom_range(0, 120)));
                    ready_pct    = 25;
                    sender_gappy = 1'b1;
                end
                default: begin
                    apply_config(1'b1, 1'b1, 1'b0, 1'b0, 8'd31, 8'd32, 8'hFF);
                    ready_pct    = 60;
                    sender_gappy = 1'b1;
                end
            endcase
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                if (cur_style)
                    random_seq_words();
                else
                    random_plain_word();
            end
        end

        drain_idle();
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
